FILE: src/mono_framebuffer_draw_engine_defines.svh
// Assertion macros shared by the frame buffer draw engine RTL.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MFDE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfde same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MFDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfde next-cycle check failed");

`endif

FILE: src/mfde_pkg.sv
// Constants and types of the monochrome frame buffer draw engine.
`default_nettype none

package mfde_pkg;

	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_PAGES   = 8;
	localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
	localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int ADDR_W         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		OP_POINT = 3'd0,
		OP_LINE  = 3'd1,
		OP_FILL  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PLOT,
		ST_WRITE,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: src/mfde_if.sv
// Request and result channel interfaces of the frame buffer draw engine.
`default_nettype none

interface mfde_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] x_a;
	logic [7:0] y_a;
	logic [7:0] x_b;
	logic [7:0] y_b;
	logic       pixel_on;

	modport source (output valid, op, x_a, y_a, x_b, y_b, pixel_on, input ready);
	modport sink (input valid, op, x_a, y_a, x_b, y_b, pixel_on, output ready);
endinterface

interface mfde_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic [2:0] op_echo;

	modport source (output valid, read_byte, op_echo, input ready);
	modport sink (input valid, read_byte, op_echo, output ready);
endinterface

`default_nettype wire

FILE: src/mfde_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module mfde_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/mono_framebuffer_draw_engine.sv
// Top level of the monochrome frame buffer draw engine.
//
// Requests arrive on cmd (valid/ready); each request yields exactly one result on rsp,
// carrying the echoed op code and, for a read, the stored byte (zero otherwise).
// The frame buffer is a 1024 x 8 RAM with a registered read port. Every on-screen pixel
// is a read-modify-write: read in ST_PLOT, written back in ST_WRITE, so the next pixel
// never sees a stale byte. Off-screen pixels are skipped in ST_PLOT and touch nothing.
// Request paths: point and line plot each pixel through ST_PLOT and ST_WRITE;
//   fill walks the rectangle column by column in the same way, or goes straight to ST_DONE
//   when x_a > x_b or y_a > y_b; clear all zeroes every byte in ST_CLEAR;
//   read goes through ST_RDWAIT; an unknown op goes straight to ST_DONE.
// One request is worked on at a time; cmd.ready is high only while idle.
// The result sits in an output register, so a new request is taken while an earlier
// result still waits; if the receiver stalls, the next finished request waits for it.
// After arst_n is released, a clearing pass over all 1024 bytes zeroes the RAM while
// cmd.ready stays low; it produces no result.
`default_nettype none
`include "mono_framebuffer_draw_engine_defines.svh"

module mono_framebuffer_draw_engine
	import mfde_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	mfde_cmd_if.sink   cmd,
	mfde_rsp_if.source rsp
);

	localparam addr_t CLR_LAST = addr_t'(STORE_BYTES - 1);

	state_t state_q, state_d;

	logic       out_valid_q;
	logic       clr_cmd_q;
	addr_t      clr_cnt_q;

	logic [2:0] op_q;
	logic       on_q;
	logic [7:0] cx_q, cy_q;
	logic [7:0] x_end_q, y_start_q, y_end_q;
	logic [7:0] dx_q, dy_q, dist_q;
	logic [8:0] ex_q, ey_q, k_q;
	logic       sx_neg_q, sy_neg_q;
	logic       rd_ok_q;
	logic [7:0] rd_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_op_q;

	logic       cmd_accept;
	logic       ram_we, ram_re;
	addr_t      ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;
	logic       advance, load_out, step_done;
	logic [7:0] cx_n, cy_n;
	logic [8:0] ex_n, ey_n, k_n, ex_sum, ey_sum;
	logic [7:0] dx_in, dy_in;
	addr_t      pix_addr, rd_addr;
	logic       pix_ok, rd_ok_in;
	logic [7:0] pix_mask;

	assign cmd_accept = cmd.valid && cmd.ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.read_byte = out_byte_q;
	assign rsp.op_echo   = out_op_q;

	// Pages are mirrored: row 0 lives in the last page, bit 7.
	assign pix_ok   = (9'(cx_q) < 9'(SCREEN_COLUMNS)) && (9'(cy_q) < 9'(SCREEN_ROWS));
	assign pix_addr = addr_t'(int'(cx_q) * SCREEN_PAGES + (SCREEN_PAGES - 1)
		- int'(cy_q[7:3]));
	assign pix_mask = 8'h80 >> cy_q[2:0];

	assign rd_ok_in = (9'(cmd.x_a) < 9'(SCREEN_COLUMNS)) && (9'(cmd.y_a) < 9'(SCREEN_PAGES));
	assign rd_addr  = addr_t'(int'(cmd.x_a) * SCREEN_PAGES + int'(cmd.y_a));

	assign dx_in = (cmd.x_b >= cmd.x_a) ? cmd.x_b - cmd.x_a : cmd.x_a - cmd.x_b;
	assign dy_in = (cmd.y_b >= cmd.y_a) ? cmd.y_b - cmd.y_a : cmd.y_a - cmd.y_b;

	mfde_ram #(
		.DATA_W(8),
		.DEPTH (STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Walk to the next pixel of the current line or fill.
	always_comb begin
		step_done = 1'b0;
		cx_n      = cx_q;
		cy_n      = cy_q;
		ex_n      = ex_q;
		ey_n      = ey_q;
		k_n       = k_q;
		ex_sum    = ex_q + 9'(dx_q);
		ey_sum    = ey_q + 9'(dy_q);
		case (op_q)
			OP_LINE: begin
				if (k_q == 9'(dist_q) + 9'd1) begin
					step_done = 1'b1;
				end else begin
					k_n  = k_q + 9'd1;
					ex_n = ex_sum;
					ey_n = ey_sum;
					if (ex_sum > 9'(dist_q)) begin
						ex_n = ex_sum - 9'(dist_q);
						cx_n = sx_neg_q ? cx_q - 8'd1 : cx_q + 8'd1;
					end
					if (ey_sum > 9'(dist_q)) begin
						ey_n = ey_sum - 9'(dist_q);
						cy_n = sy_neg_q ? cy_q - 8'd1 : cy_q + 8'd1;
					end
				end
			end
			OP_FILL: begin
				if (cy_q == y_end_q) begin
					if (cx_q == x_end_q) begin
						step_done = 1'b1;
					end else begin
						cx_n = cx_q + 8'd1;
						cy_n = y_start_q;
					end
				end else begin
					cy_n = cy_q + 8'd1;
				end
			end
			default: begin
				step_done = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = (state_q == ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = clr_cnt_q;
		ram_wdata = 8'h00;
		ram_re    = 1'b0;
		ram_raddr = pix_addr;
		advance   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					case (cmd.op)
						OP_POINT, OP_LINE: begin
							state_d = ST_PLOT;
						end
						OP_FILL: begin
							state_d = (cmd.x_a <= cmd.x_b && cmd.y_a <= cmd.y_b)
								? ST_PLOT : ST_DONE;
						end
						OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						OP_READ: begin
							ram_re    = rd_ok_in;
							ram_raddr = rd_addr;
							state_d   = ST_RDWAIT;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_PLOT: begin
				if (pix_ok) begin
					ram_re  = 1'b1;
					state_d = ST_WRITE;
				end else begin
					advance = 1'b1;
					state_d = step_done ? ST_DONE : ST_PLOT;
				end
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = pix_addr;
				ram_wdata = on_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
				advance   = 1'b1;
				state_d   = step_done ? ST_DONE : ST_PLOT;
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			clr_cmd_q   <= 1'b0;
			clr_cnt_q   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_accept) begin
				clr_cmd_q <= (cmd.op == OP_CLEAR);
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + addr_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			op_q      <= cmd.op;
			on_q      <= cmd.pixel_on;
			cx_q      <= cmd.x_a;
			cy_q      <= cmd.y_a;
			x_end_q   <= cmd.x_b;
			y_start_q <= cmd.y_a;
			y_end_q   <= cmd.y_b;
			dx_q      <= dx_in;
			dy_q      <= dy_in;
			dist_q    <= (dx_in > dy_in) ? dx_in : dy_in;
			ex_q      <= '0;
			ey_q      <= '0;
			k_q       <= '0;
			sx_neg_q  <= (cmd.x_b < cmd.x_a);
			sy_neg_q  <= (cmd.y_b < cmd.y_a);
			rd_ok_q   <= rd_ok_in;
			rd_q      <= 8'h00;
		end
		if (advance) begin
			cx_q <= cx_n;
			cy_q <= cy_n;
			ex_q <= ex_n;
			ey_q <= ey_n;
			k_q  <= k_n;
		end
		if (state_q == ST_RDWAIT) begin
			rd_q <= rd_ok_q ? ram_rdata : 8'h00;
		end
		if (load_out) begin
			out_byte_q <= rd_q;
			out_op_q   <= op_q;
		end
	end

	`MFDE_ASSERT_IMP(a_write_only_busy, ram_we, state_q == ST_CLEAR || state_q == ST_WRITE)
	`MFDE_ASSERT_NEXT(a_busy_after_accept, cmd_accept, !cmd.ready)
	`MFDE_ASSERT_IMP(a_line_count, state_q == ST_PLOT && op_q == OP_LINE, k_q <= 9'(dist_q) + 9'd1)
	`MFDE_ASSERT_IMP(a_write_in_range, ram_we, int'(ram_waddr) < STORE_BYTES)

endmodule

`default_nettype wire
